// File: hdl/dotq_pkg.sv
// shared types and constants of the deadline ordered task queue
`timescale 1ns / 1ps

package dotq_pkg;

	// default sizes
	localparam int DEPTH_DEF       = 16;
	localparam int TIME_BITS_DEF   = 32;
	localparam int HANDLE_BITS_DEF = 8;

	// fixed port widths
	localparam int HANDLE_PORT_W  = 8;
	localparam int DELAY_W        = 16;
	localparam int PENDING_W      = 5;

	// input command codes
	typedef enum logic {
		CMD_SCHEDULE = 1'b0,
		CMD_TICK     = 1'b1
	} command_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_EXPIRED  = 2'd2
	} kind_t;

	// per cell load select
	typedef enum logic [1:0] {
		OP_HOLD       = 2'd0,
		OP_LOAD_LEFT  = 2'd1,
		OP_LOAD_RIGHT = 2'd2,
		OP_LOAD_NEW   = 2'd3
	} cell_op_t;

endpackage

// File: hdl/dotq_cell.sv
// one storage cell of the sorted deadline chain
`timescale 1ns / 1ps

module dotq_cell #(
	parameter int TIME_BITS   = dotq_pkg::TIME_BITS_DEF,
	parameter int HANDLE_BITS = dotq_pkg::HANDLE_BITS_DEF
) (
	input  logic                   clk,
	input  dotq_pkg::cell_op_t     op,
	input  logic [TIME_BITS-1:0]   key,
	input  logic [HANDLE_BITS-1:0] new_handle,
	input  logic [TIME_BITS-1:0]   left_deadline,
	input  logic [HANDLE_BITS-1:0] left_handle,
	input  logic [TIME_BITS-1:0]   right_deadline,
	input  logic [HANDLE_BITS-1:0] right_handle,
	output logic [TIME_BITS-1:0]   deadline,
	output logic [HANDLE_BITS-1:0] handle,
	output logic                   due
);
	import dotq_pkg::*;

	logic [TIME_BITS-1:0]   deadline_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [TIME_BITS-1:0]   diff;

	// wrapping compare: stored deadline at or before key
	assign diff     = deadline_q - key;
	assign due      = (diff == '0) || diff[TIME_BITS-1];
	assign deadline = deadline_q;
	assign handle   = handle_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD_LEFT: begin
				deadline_q <= left_deadline;
				handle_q   <= left_handle;
			end
			OP_LOAD_RIGHT: begin
				deadline_q <= right_deadline;
				handle_q   <= right_handle;
			end
			OP_LOAD_NEW: begin
				deadline_q <= key;
				handle_q   <= new_handle;
			end
			default: begin
				deadline_q <= deadline_q;
				handle_q   <= handle_q;
			end
		endcase
	end

endmodule

// File: hdl/deadline_ordered_task_queue_top.sv
// top level of the deadline ordered task queue
`timescale 1ns / 1ps

// Hardware timer queue kept as a chain of sorted cells, earliest deadline in cell 0.
// Input channel (in_valid/in_ready): command, task_handle, delay_ticks.
//   schedule: deadline = now + delay_ticks is inserted in order; one result,
//   accepted or rejected when full.
//   tick: time advances by one, then every task due at or before now leaves,
//   earliest first, one expired result each, the final one marked by last.
// Output channel (out_valid/out_ready): kind, task_handle_out, pending, last,
// from a single output register.
// Timing: in_ready is high only between items. For a schedule the transfer
// cycle forms the deadline; the insert state then compares all cells in
// parallel, shifts the later ones right by one and loads the result. A tick
// advances time in its transfer cycle, then pops one head per cycle while it
// is due and the output register can take it, each pop shifting the whole
// chain left by one. A stalled receiver holds the output register; pops and
// inserts wait for it, and the next item is taken once the current one is done.
// Reset clears time, fill count, state and output valid; cell contents are
// don't care until written since only the first pending cells are read.
module deadline_ordered_task_queue_top #(
	parameter int DEPTH       = dotq_pkg::DEPTH_DEF,
	parameter int TIME_BITS   = dotq_pkg::TIME_BITS_DEF,
	parameter int HANDLE_BITS = dotq_pkg::HANDLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  command,
	input  logic [dotq_pkg::HANDLE_PORT_W-1:0]    task_handle,
	input  logic [dotq_pkg::DELAY_W-1:0]          delay_ticks,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output dotq_pkg::kind_t                       kind,
	output logic [dotq_pkg::HANDLE_PORT_W-1:0]    task_handle_out,
	output logic [dotq_pkg::PENDING_W-1:0]        pending,
	output logic                                  last
);
	import dotq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_INS  = 3'b010,
		S_POP  = 3'b100
	} state_t;

	state_t                 state_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [TIME_BITS-1:0]   key_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [CNT_W-1:0]       count_q;

	// output register
	logic                     out_valid_q;
	kind_t                    kind_q;
	logic [HANDLE_PORT_W-1:0] handle_out_q;
	logic [PENDING_W-1:0]     pending_q;
	logic                     last_q;

	// cell chain
	logic [TIME_BITS-1:0]   cell_deadline [DEPTH];
	logic [HANDLE_BITS-1:0] cell_handle   [DEPTH];
	cell_op_t               cell_op       [DEPTH];
	logic [DEPTH-1:0]       cell_due;
	logic [DEPTH-1:0]       cell_vld;
	logic [DEPTH-1:0]       hit;
	logic [DEPTH-1:0]       sfx;      // no stored task at or before key from here up

	logic in_xfer;
	logic slot_free;
	logic full;
	logic do_ins;
	logic emit_ins;
	logic do_pop;
	logic pop_last;

	// width adaptation of handles and counts
	logic [HANDLE_BITS+HANDLE_PORT_W-1:0] handle_in_ext;
	logic [HANDLE_BITS-1:0]               handle_in;
	logic [HANDLE_BITS-1:0]               handle_sel;
	logic [HANDLE_BITS+HANDLE_PORT_W-1:0] handle_out_ext;
	logic [CNT_W-1:0]                     count_next;
	logic [CNT_W+PENDING_W-1:0]           pending_ext;
	logic [TIME_BITS-1:0]                 delay_ext;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign full      = (count_q == CNT_W'(DEPTH));

	assign handle_in_ext = {{HANDLE_BITS{1'b0}}, task_handle};
	assign handle_in     = handle_in_ext[HANDLE_BITS-1:0];
	assign delay_ext     = {{(TIME_BITS-DELAY_W){1'b0}}, delay_ticks};

	// occupancy decides which cells hold live tasks
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			assign cell_vld[gi] = (count_q > CNT_W'(gi));
			assign hit[gi]      = cell_vld[gi] && cell_due[gi];
			assign sfx[gi]      = ~|hit[DEPTH-1:gi];

			dotq_cell #(
				.TIME_BITS   (TIME_BITS),
				.HANDLE_BITS (HANDLE_BITS)
			) u_cell (
				.clk            (clk),
				.op             (cell_op[gi]),
				.key            (key_q),
				.new_handle     (handle_q),
				.left_deadline  (cell_deadline[(gi == 0) ? 0 : gi - 1]),
				.left_handle    (cell_handle[(gi == 0) ? 0 : gi - 1]),
				.right_deadline (cell_deadline[(gi == DEPTH - 1) ? gi : gi + 1]),
				.right_handle   (cell_handle[(gi == DEPTH - 1) ? gi : gi + 1]),
				.deadline       (cell_deadline[gi]),
				.handle         (cell_handle[gi]),
				.due            (cell_due[gi])
			);
		end
	endgenerate

	// insert lands after the last task at or before the new deadline
	assign emit_ins = (state_q == S_INS) && slot_free;
	assign do_ins   = emit_ins && !full;
	// pop the head while it is due and the output register can take it
	assign do_pop   = (state_q == S_POP) && hit[0] && slot_free;
	assign pop_last = !hit[1];

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_op[i] = OP_HOLD;
			if (do_pop) begin
				cell_op[i] = OP_LOAD_RIGHT;
			end else if (do_ins) begin
				if (i > 0 && sfx[(i > 0) ? i - 1 : 0]) begin
					cell_op[i] = OP_LOAD_LEFT;
				end else if (sfx[i]) begin
					cell_op[i] = OP_LOAD_NEW;
				end
			end
		end
	end

	assign handle_sel     = do_pop ? cell_handle[0] : handle_q;
	assign handle_out_ext = {{HANDLE_PORT_W{1'b0}}, handle_sel};
	assign count_next     = do_pop ? (count_q - 1'b1) :
	                        do_ins ? (count_q + 1'b1) : count_q;
	assign pending_ext    = {{PENDING_W{1'b0}}, count_next};

	// sequencer, time, fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			now_q   <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_next;
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (command == CMD_TICK) begin
							now_q   <= now_q + 1'b1;
							state_q <= S_POP;
						end else begin
							state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					if (emit_ins) begin
						state_q <= S_IDLE;
					end
				end
				S_POP: begin
					if (!hit[0] || (do_pop && pop_last)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// key and handle of the item in work
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			handle_q <= handle_in;
			if (command == CMD_TICK) begin
				key_q <= now_q + 1'b1;
			end else begin
				key_q <= now_q + delay_ext;
			end
		end
	end

	// output register, held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_ins || do_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ins || do_pop) begin
			handle_out_q <= handle_out_ext[HANDLE_PORT_W-1:0];
			pending_q    <= pending_ext[PENDING_W-1:0];
			if (do_pop) begin
				kind_q <= KIND_EXPIRED;
				last_q <= pop_last;
			end else begin
				kind_q <= full ? KIND_REJECTED : KIND_ACCEPTED;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign task_handle_out = handle_out_q;
	assign pending         = pending_q;
	assign last            = last_q;

endmodule
